>>> rtl/core/mvg_pkg.sv
// Package: shared types, codes and constants of the MIDI voice message generator.
`default_nettype none
package mvg_pkg;

  localparam int unsigned DefVoices = 8;

  // Sequencer event kinds
  typedef enum logic [2:0] {
    MODE_START      = 3'd0,
    MODE_STOP       = 3'd1,
    MODE_TICK       = 3'd2,
    MODE_CMD        = 3'd3,
    MODE_PLAY_START = 3'd4,
    MODE_PLAY_STOP  = 3'd5
  } mode_t;

  // Voice commands
  typedef enum logic [3:0] {
    CMD_RETRIG    = 4'd0,
    CMD_VELOCITY  = 4'd1,
    CMD_VOLUME    = 4'd2,
    CMD_CC        = 4'd3,
    CMD_PROGRAM   = 4'd4,
    CMD_BEND_RAW  = 4'd5,
    CMD_BEND_FINE = 4'd6,
    CMD_PAN       = 4'd7,
    CMD_CHAN_AT   = 4'd8,
    CMD_POLY_AT   = 4'd9,
    CMD_BANK      = 4'd10
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_OUT_DEVICE     = 3'd0,
    REG_MIDI_CHANNEL   = 3'd1,
    REG_NOTE_LENGTH    = 3'd2,
    REG_TRANSPOSE      = 3'd3,
    REG_SEND_CLOCK     = 3'd4,
    REG_SEND_TRANSPORT = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // Status nibbles and system bytes
  localparam logic [3:0] StNoteOff  = 4'h8;
  localparam logic [3:0] StNoteOn   = 4'h9;
  localparam logic [3:0] StPolyAt   = 4'hA;
  localparam logic [3:0] StCtrl     = 4'hB;
  localparam logic [3:0] StProgram  = 4'hC;
  localparam logic [3:0] StChanAt   = 4'hD;
  localparam logic [3:0] StBend     = 4'hE;
  localparam logic [7:0] SysClock   = 8'hF8;
  localparam logic [7:0] SysStart   = 8'hFA;
  localparam logic [7:0] SysStop    = 8'hFC;
  localparam logic [7:0] CcVolume   = 8'd7;
  localparam logic [7:0] CcPan      = 8'd10;
  localparam logic [7:0] CcBankMsb  = 8'd0;
  localparam logic [7:0] CcBankLsb  = 8'd32;
  localparam logic [7:0] CcAllOff   = 8'd123;
  localparam logic [6:0] VelMax     = 7'd127;
  localparam logic signed [16:0] BendCenter = 17'sh2000;
  localparam logic signed [16:0] BendMax    = 17'sh3FFF;

  typedef struct packed {
    logic [3:0] dev;
    logic [1:0] cnt;
    logic [7:0] d2;
    logic [7:0] d1;
    logic [7:0] status;
  } msg_t;

  // Voice state updates requested by the sequencer
  typedef struct packed {
    logic       start;
    logic       clr_play;
    logic       clr_pend;
    logic       tick_wr;
    logic [8:0] tick_val;
    logic       retrig_wr;
    logic       retrig_val;
    logic       period_wr;
    logic       vel_wr;
    logic [6:0] vel_val;
    logic       clr_all;
    logic       run_set;
    logic       run_clr;
  } act_t;

endpackage
`default_nettype wire

>>> rtl/core/midi_voice_message_generator_core.sv
// Top level: per-voice MIDI message sequencer with a one-message hold stage.
// An event keeps the sequencer busy for one step per message or check, the last of them the
// flush; the next event is accepted once the sequencer is back in idle.
// Play start scans the voices one per cycle while the output does not stall the sequencer.
// A message waiting on out_tready stalls the sequencer; in_tready is high only when idle.
// Reset (rst_n low, synchronous) clears all voices, velocity to 127, config to zero.
`default_nettype none
module midi_voice_message_generator_core #(
  parameter int unsigned VOICES = mvg_pkg::DefVoices
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // voice[2:0], note[9:3], command[13:10], value[29:14], update_tick[30], clock_slice[31]
  input  wire logic [31:0] in_tdata,
  // mode[2:0]
  input  wire logic [2:0]  in_tuser,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // status_byte[7:0], data_one[15:8], data_two[23:16], byte_count[25:24],
  // target_device[29:26], zero fill[31:30]
  output      logic [31:0] out_tdata,
  output      logic        out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);
  import mvg_pkg::*;

  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  // Configuration
  logic [3:0] out_device_r, midi_channel_r;
  logic [7:0] note_length_r, transpose_r;
  logic       send_clock_r, send_transport_r;

  // Voice state
  logic [6:0]  voice_note_r     [VOICES];
  logic [3:0]  voice_channel_r  [VOICES];
  logic [3:0]  voice_device_r   [VOICES];
  logic [7:0]  retrig_period_r  [VOICES];
  logic [8:0]  ticks_left_r     [VOICES];
  logic [6:0]  voice_velocity_r [VOICES];
  logic [VOICES-1:0] pending_r, playing_r, retrig_r;
  logic        running_r;

  // Event registers
  logic [2:0]  ev_mode_r, ev_voice_r;
  logic [6:0]  ev_note_r;
  logic [3:0]  ev_cmd_r;
  logic [15:0] ev_value_r;
  logic        ev_upd_r, ev_slice_r;

  state_t      state_r, state_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [VW-1:0] scan_r, scan_nxt;

  msg_t        hold_r, out_r, msg;
  logic        hold_valid_r, out_valid_r, out_last_r;
  logic        emit, go, in_acc;
  act_t        act;

  logic [VW-1:0] vidx, ridx;
  logic [6:0]  cur_note, cur_vel;
  logic [3:0]  cur_ch, cur_dev, cmd_ch, cmd_dev;
  logic        cur_play;
  logic [8:0]  cur_ticks;
  logic [VOICES-1:0] below_mask;
  logic        bad_voice;
  logic signed [8:0]  tr_sum;
  logic [6:0]  tr_note;
  logic signed [16:0] bend_sum;
  logic [13:0] bend_val;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r};
  assign out_tlast  = out_last_r;

  // Voice read port
  assign vidx      = VW'(ev_voice_r);
  assign ridx      = (state_r == ST_SCAN) ? scan_r : vidx;
  assign cur_note  = voice_note_r[ridx];
  assign cur_ch    = voice_channel_r[ridx];
  assign cur_dev   = voice_device_r[ridx];
  assign cur_vel   = voice_velocity_r[ridx];
  assign cur_ticks = ticks_left_r[ridx];
  assign cur_play  = playing_r[ridx];
  assign cmd_ch    = cur_play ? cur_ch : midi_channel_r;
  assign cmd_dev   = cur_play ? cur_dev : out_device_r;
  assign bad_voice = ({29'd0, ev_voice_r} >= 32'(VOICES));

  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      below_mask[i] = (i < int'(vidx));
    end
  end

  // Transpose and clamp
  assign tr_sum  = $signed({2'b00, ev_note_r}) + $signed({transpose_r[7], transpose_r});
  assign tr_note = tr_sum[8] ? 7'd0 : (tr_sum[7] ? 7'd127 : tr_sum[6:0]);

  // Fine bend with saturation
  assign bend_sum = BendCenter + $signed({ev_value_r[15], ev_value_r});
  assign bend_val = bend_sum[16] ? 14'd0 :
                    (bend_sum > BendMax) ? 14'h3FFF : bend_sum[13:0];

  // A step may emit only when the hold stage can move on
  assign go = !hold_valid_r || !out_valid_r || out_tready;

  // Sequencer: next state and actions
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    scan_nxt  = scan_r;
    emit      = 1'b0;
    msg       = '0;
    act       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          step_nxt = 2'd0;
          scan_nxt = '0;
          state_nxt = (in_tuser == MODE_PLAY_START) ? ST_SCAN : ST_RUN;
        end
      end
      ST_SCAN: begin
        if (go) begin
          if (cur_play) begin
            emit = 1'b1;
            msg  = '{dev: cur_dev, cnt: 2'd3, d2: 8'd0, d1: {1'b0, cur_note},
                     status: {StNoteOff, cur_ch}};
            act.clr_play = 1'b1;
          end
          if (scan_r == VW'(VOICES - 1)) begin
            state_nxt = ST_RUN;
          end else begin
            scan_nxt = scan_r + 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (go) begin
          state_nxt = ST_FLUSH;
          if (bad_voice && ev_mode_r <= MODE_CMD) begin
            state_nxt = ST_FLUSH;
          end else begin
            case (ev_mode_r)
              MODE_START: begin
                if (cur_play) begin
                  emit = 1'b1;
                  msg  = '{dev: cur_dev, cnt: 2'd3, d2: 8'd0, d1: {1'b0, cur_note},
                           status: {StNoteOff, cur_ch}};
                end
                act.start = 1'b1;
              end
              MODE_STOP: begin
                if (step_r == 2'd0) begin
                  if (cur_play) begin
                    emit = 1'b1;
                    msg  = '{dev: cur_dev, cnt: 2'd3, d2: 8'd0, d1: {1'b0, cur_note},
                             status: {StNoteOff, cur_ch}};
                    act.clr_play = 1'b1;
                    step_nxt  = 2'd1;
                    state_nxt = ST_RUN;
                  end
                end else if (!(|playing_r)) begin
                  emit = 1'b1;
                  msg  = '{dev: cur_dev, cnt: 2'd3, d2: 8'd0, d1: CcAllOff,
                           status: {StCtrl, cur_ch}};
                end
              end
              MODE_TICK: begin
                case (step_r)
                  2'd0: begin
                    if (pending_r[vidx]) begin
                      emit = 1'b1;
                      msg  = '{dev: cur_dev, cnt: 2'd3, d2: {1'b0, cur_vel},
                               d1: {1'b0, cur_note}, status: {StNoteOn, cur_ch}};
                      act.clr_pend = 1'b1;
                    end
                    step_nxt  = 2'd1;
                    state_nxt = ST_RUN;
                  end
                  2'd1: begin
                    if (send_clock_r && cur_play && ev_slice_r &&
                        !(|(playing_r & below_mask))) begin
                      emit = 1'b1;
                      msg  = '{dev: out_device_r, cnt: 2'd1, d2: 8'd0, d1: 8'd0,
                               status: SysClock};
                    end
                    step_nxt  = 2'd2;
                    state_nxt = ST_RUN;
                  end
                  2'd2: begin
                    if (ev_upd_r && !cur_ticks[8] && (cur_ticks != 9'd0)) begin
                      act.tick_wr  = 1'b1;
                      act.tick_val = cur_ticks - 9'd1;
                      if (cur_ticks == 9'd1) begin
                        emit = 1'b1;
                        msg  = '{dev: cur_dev, cnt: 2'd3, d2: 8'd0, d1: {1'b0, cur_note},
                                 status: {StNoteOff, cur_ch}};
                        if (!retrig_r[vidx]) begin
                          act.clr_play = 1'b1;
                        end else begin
                          act.tick_val = {1'b0, retrig_period_r[vidx]};
                          step_nxt  = 2'd3;
                          state_nxt = ST_RUN;
                        end
                      end
                    end
                  end
                  default: begin
                    emit = 1'b1;
                    msg  = '{dev: cur_dev, cnt: 2'd3, d2: {1'b0, cur_vel},
                             d1: {1'b0, cur_note}, status: {StNoteOn, cur_ch}};
                  end
                endcase
              end
              MODE_CMD: begin
                case (ev_cmd_r)
                  CMD_RETRIG: begin
                    act.retrig_wr  = 1'b1;
                    act.retrig_val = (ev_value_r[7:0] != 8'd0);
                    if (ev_value_r[7:0] != 8'd0) begin
                      act.period_wr = 1'b1;
                      act.tick_wr   = 1'b1;
                      act.tick_val  = {1'b0, ev_value_r[7:0]};
                    end
                  end
                  CMD_VELOCITY: begin
                    act.vel_wr  = 1'b1;
                    act.vel_val = (|ev_value_r[15:8]) ? VelMax : ev_value_r[7:1];
                  end
                  CMD_VOLUME: begin
                    emit = 1'b1;
                    msg  = '{dev: cmd_dev, cnt: 2'd3, d2: ev_value_r[8:1], d1: CcVolume,
                             status: {StCtrl, cmd_ch}};
                  end
                  CMD_CC: begin
                    emit = 1'b1;
                    msg  = '{dev: cmd_dev, cnt: 2'd3, d2: {1'b0, ev_value_r[6:0]},
                             d1: {1'b0, ev_value_r[14:8]}, status: {StCtrl, cmd_ch}};
                  end
                  CMD_PROGRAM: begin
                    emit = 1'b1;
                    msg  = '{dev: cmd_dev, cnt: 2'd2, d2: 8'd0,
                             d1: {1'b0, ev_value_r[6:0]}, status: {StProgram, cmd_ch}};
                  end
                  CMD_BEND_RAW: begin
                    emit = 1'b1;
                    msg  = '{dev: cmd_dev, cnt: 2'd3, d2: {1'b0, ev_value_r[13:7]},
                             d1: {1'b0, ev_value_r[6:0]}, status: {StBend, cmd_ch}};
                  end
                  CMD_BEND_FINE: begin
                    emit = 1'b1;
                    msg  = '{dev: cmd_dev, cnt: 2'd3, d2: {1'b0, bend_val[13:7]},
                             d1: {1'b0, bend_val[6:0]}, status: {StBend, cmd_ch}};
                  end
                  CMD_PAN: begin
                    emit = 1'b1;
                    msg  = '{dev: cmd_dev, cnt: 2'd3, d2: {1'b0, ev_value_r[6:0]},
                             d1: CcPan, status: {StCtrl, cmd_ch}};
                  end
                  CMD_CHAN_AT: begin
                    emit = 1'b1;
                    msg  = '{dev: cmd_dev, cnt: 2'd2, d2: 8'd0,
                             d1: {1'b0, ev_value_r[6:0]}, status: {StChanAt, cmd_ch}};
                  end
                  CMD_POLY_AT: begin
                    emit = 1'b1;
                    msg  = '{dev: cmd_dev, cnt: 2'd3, d2: {1'b0, ev_value_r[6:0]},
                             d1: {1'b0, ev_value_r[14:8]}, status: {StPolyAt, cmd_ch}};
                  end
                  CMD_BANK: begin
                    emit = 1'b1;
                    if (step_r == 2'd0) begin
                      msg = '{dev: cmd_dev, cnt: 2'd3, d2: {1'b0, ev_value_r[14:8]},
                              d1: CcBankMsb, status: {StCtrl, cmd_ch}};
                      step_nxt  = 2'd1;
                      state_nxt = ST_RUN;
                    end else begin
                      msg = '{dev: cmd_dev, cnt: 2'd3, d2: {1'b0, ev_value_r[6:0]},
                              d1: CcBankLsb, status: {StCtrl, cmd_ch}};
                    end
                  end
                  default: ;
                endcase
              end
              MODE_PLAY_START: begin
                act.clr_all = 1'b1;
                if (send_transport_r && !running_r) begin
                  emit = 1'b1;
                  msg  = '{dev: out_device_r, cnt: 2'd1, d2: 8'd0, d1: 8'd0,
                           status: SysStart};
                  act.run_set = 1'b1;
                end
              end
              MODE_PLAY_STOP: begin
                if (running_r) begin
                  emit = 1'b1;
                  msg  = '{dev: out_device_r, cnt: 2'd1, d2: 8'd0, d1: 8'd0,
                           status: SysStop};
                  act.run_clr = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_FLUSH: begin
        if (go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers and output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= 2'd0;
      scan_r       <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      scan_r  <= scan_nxt;
      if (emit) begin
        if (hold_valid_r) begin
          out_valid_r <= 1'b1;
        end else if (out_valid_r && out_tready) begin
          out_valid_r <= 1'b0;
        end
        hold_valid_r <= 1'b1;
      end else if (state_r == ST_FLUSH && go && hold_valid_r) begin
        out_valid_r  <= 1'b1;
        hold_valid_r <= 1'b0;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Message payload
  always_ff @(posedge clk) begin
    if (emit) begin
      hold_r <= msg;
      if (hold_valid_r) begin
        out_r      <= hold_r;
        out_last_r <= 1'b0;
      end
    end else if (state_r == ST_FLUSH && go && hold_valid_r) begin
      out_r      <= hold_r;
      out_last_r <= 1'b1;
    end
  end

  // Event capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_mode_r  <= in_tuser;
      ev_voice_r <= in_tdata[2:0];
      ev_note_r  <= in_tdata[9:3];
      ev_cmd_r   <= in_tdata[13:10];
      ev_value_r <= in_tdata[29:14];
      ev_upd_r   <= in_tdata[30];
      ev_slice_r <= in_tdata[31];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_device_r     <= 4'd0;
      midi_channel_r   <= 4'd0;
      note_length_r    <= 8'd0;
      transpose_r      <= 8'd0;
      send_clock_r     <= 1'b0;
      send_transport_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OUT_DEVICE:     out_device_r     <= cfg_wdata[3:0];
        REG_MIDI_CHANNEL:   midi_channel_r   <= cfg_wdata[3:0];
        REG_NOTE_LENGTH:    note_length_r    <= cfg_wdata;
        REG_TRANSPOSE:      transpose_r      <= cfg_wdata;
        REG_SEND_CLOCK:     send_clock_r     <= cfg_wdata[0];
        REG_SEND_TRANSPORT: send_transport_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Voice state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        voice_note_r[i]     <= 7'd0;
        voice_channel_r[i]  <= 4'd0;
        voice_device_r[i]   <= 4'd0;
        retrig_period_r[i]  <= 8'd0;
        ticks_left_r[i]     <= 9'd0;
        voice_velocity_r[i] <= VelMax;
      end
      pending_r <= '0;
      playing_r <= '0;
      retrig_r  <= '0;
      running_r <= 1'b0;
    end else begin
      if (act.start) begin
        pending_r[ridx]       <= 1'b1;
        playing_r[ridx]       <= 1'b1;
        retrig_r[ridx]        <= 1'b0;
        voice_channel_r[ridx] <= midi_channel_r;
        voice_device_r[ridx]  <= out_device_r;
        voice_note_r[ridx]    <= tr_note;
        ticks_left_r[ridx]    <= (note_length_r != 8'd0) ? {1'b0, note_length_r} : 9'h1FF;
      end
      if (act.clr_play) playing_r[ridx] <= 1'b0;
      if (act.clr_pend) pending_r[ridx] <= 1'b0;
      if (act.tick_wr) ticks_left_r[ridx] <= act.tick_val;
      if (act.retrig_wr) retrig_r[ridx] <= act.retrig_val;
      if (act.period_wr) retrig_period_r[ridx] <= ev_value_r[7:0];
      if (act.vel_wr) voice_velocity_r[ridx] <= act.vel_val;
      if (act.clr_all) begin
        retrig_r  <= '0;
        pending_r <= '0;
      end
      if (act.run_set) running_r <= 1'b1;
      if (act.run_clr) running_r <= 1'b0;
    end
  end

`ifndef SYNTH
  a_idle_no_hold : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !hold_valid_r) else $error("held message while idle");
  a_emit_busy : assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (state_r == ST_RUN || state_r == ST_SCAN)) else $error("emit outside run");
  a_flush_done : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && !hold_valid_r) |=> state_r == ST_IDLE)
    else $error("flush did not finish");
  a_hold_moves : assert property (@(posedge clk) disable iff (!rst_n)
    (emit && hold_valid_r) |=> out_valid_r) else $error("held message lost");
`endif

endmodule
`default_nettype wire
